// ===== rtl/spd_pkg.sv =====
package spd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned EVENT_W = 3;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'd1;

  localparam logic [CFG_W-1:0] SYNC_FIRST_RESET  = 8'd147;
  localparam logic [CFG_W-1:0] SYNC_SECOND_RESET = 8'd224;

  localparam logic [EVENT_W-1:0] EV_NONE = 3'd0;
  localparam logic [EVENT_W-1:0] EV_DATA = 3'd1;
  localparam logic [EVENT_W-1:0] EV_GOOD = 3'd2;
  localparam logic [EVENT_W-1:0] EV_BAD  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_SYNC = 3'd4;

  typedef enum logic [6:0] {
    PH_HUNT    = 7'b0000001,
    PH_WAIT2   = 7'b0000010,
    PH_ID      = 7'b0000100,
    PH_LEN     = 7'b0001000,
    PH_PAYLOAD = 7'b0010000,
    PH_CK_LOW  = 7'b0100000,
    PH_CK_HIGH = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [COUNT_W-1:0] error_count;
    logic [BYTE_W-1:0]  byte_index;
    logic [BYTE_W-1:0]  data_byte;
    logic [BYTE_W-1:0]  packet_length;
    logic [BYTE_W-1:0]  msg_id;
    logic [EVENT_W-1:0] event_res;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]   data;
  } cfg_write_t;

endpackage

// ===== rtl/spd_in_stage.sv =====
module spd_in_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [spd_pkg::BYTE_W-1:0] s_byte,
  input  logic                      take,
  output logic                      in_valid,
  output logic [spd_pkg::BYTE_W-1:0] in_byte
);
  import spd_pkg::*;

  logic [BYTE_W-1:0] byte_q;
  logic              valid_q;

  assign s_tready = !valid_q || take;
  assign in_valid = valid_q;
  assign in_byte  = byte_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (s_tready) begin
      valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      byte_q <= s_byte;
    end
  end

endmodule

// ===== rtl/spd_core.sv =====
module spd_core (
  input  logic                       clk,
  input  logic                       rst,
  input  spd_pkg::cfg_write_t        cfg,
  input  logic                       in_valid,
  input  logic [spd_pkg::BYTE_W-1:0] in_byte,
  output logic                       take,
  output logic                       res_valid,
  input  logic                       res_ready,
  output spd_pkg::result_t           res
);
  import spd_pkg::*;

  logic [CFG_W-1:0]   sync_first;
  logic [CFG_W-1:0]   sync_second;
  phase_t             phase, phase_next;
  logic [BYTE_W-1:0]  held_id, held_id_next;
  logic [BYTE_W-1:0]  held_length, held_length_next;
  logic [BYTE_W-1:0]  payload_count, payload_count_next;
  logic [BYTE_W-1:0]  sum_a, sum_a_next;
  logic [BYTE_W-1:0]  sum_b, sum_b_next;
  logic [BYTE_W-1:0]  check_low, check_low_next;
  logic [COUNT_W-1:0] error_total, error_total_next;
  logic               err_inc;
  logic [EVENT_W-1:0] ev;
  logic [BYTE_W-1:0]  data;
  logic [BYTE_W-1:0]  idx;
  result_t            res_q;
  logic               valid_q;

  assign take      = in_valid && (!valid_q || res_ready);
  assign res_valid = valid_q;
  assign res       = res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= SYNC_FIRST_RESET;
      sync_second <= SYNC_SECOND_RESET;
    end else if (cfg.we) begin
      unique case (cfg.index)
        CFG_SYNC_FIRST:  sync_first  <= cfg.data;
        CFG_SYNC_SECOND: sync_second <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next         = phase;
    held_id_next       = held_id;
    held_length_next   = held_length;
    payload_count_next = payload_count;
    sum_a_next         = sum_a;
    sum_b_next         = sum_b;
    check_low_next     = check_low;
    err_inc            = 1'b0;
    ev                 = EV_NONE;
    data               = '0;
    idx                = '0;
    unique case (phase)
      PH_WAIT2: begin
        if (in_byte == sync_second) begin
          phase_next = PH_ID;
        end else if (in_byte != sync_first) begin
          err_inc    = 1'b1;
          ev         = EV_SYNC;
          phase_next = PH_HUNT;
        end
      end
      PH_ID: begin
        held_id_next = in_byte;
        sum_a_next   = in_byte;
        sum_b_next   = in_byte;
        phase_next   = PH_LEN;
      end
      PH_LEN: begin
        held_length_next   = in_byte;
        sum_a_next         = sum_a + in_byte;
        sum_b_next         = sum_b + sum_a_next;
        payload_count_next = '0;
        phase_next         = (in_byte != '0) ? PH_PAYLOAD : PH_CK_LOW;
      end
      PH_PAYLOAD: begin
        ev                 = EV_DATA;
        data               = in_byte;
        idx                = payload_count;
        sum_a_next         = sum_a + in_byte;
        sum_b_next         = sum_b + sum_a_next;
        payload_count_next = payload_count + 8'd1;
        if (payload_count_next >= held_length) begin
          phase_next = PH_CK_LOW;
        end
      end
      PH_CK_LOW: begin
        check_low_next = in_byte;
        phase_next     = PH_CK_HIGH;
      end
      PH_CK_HIGH: begin
        if (check_low == sum_a && in_byte == sum_b) begin
          ev = EV_GOOD;
        end else begin
          err_inc = 1'b1;
          ev      = EV_BAD;
        end
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = (in_byte == sync_first) ? PH_WAIT2 : PH_HUNT;
      end
    endcase
    error_total_next = (err_inc && error_total != '1) ? error_total + 16'd1 : error_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      held_id       <= '0;
      held_length   <= '0;
      payload_count <= '0;
      sum_a         <= '0;
      sum_b         <= '0;
      check_low     <= '0;
      error_total   <= '0;
      valid_q       <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        held_id       <= held_id_next;
        held_length   <= held_length_next;
        payload_count <= payload_count_next;
        sum_a         <= sum_a_next;
        sum_b         <= sum_b_next;
        check_low     <= check_low_next;
        error_total   <= error_total_next;
        valid_q       <= 1'b1;
      end else if (res_ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_q.event_res     <= ev;
      res_q.msg_id        <= held_id_next;
      res_q.packet_length <= held_length_next;
      res_q.data_byte     <= data;
      res_q.byte_index    <= idx;
      res_q.error_count   <= error_total_next;
    end
  end

endmodule

// ===== rtl/sync_packet_deframer.sv =====
// Datapath: an accepted input item is registered in the input stage, then its result in
// the core. Throughput: one item per cycle while the master side does not stall; the
// state update is combinational between the input register and the result register.
// Reset: synchronous, active high; hunts for the first sync byte, clears the error
// count, and restores the sync byte values 147 and 224.
module sync_packet_deframer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] msg_id, [15:8] packet_length, [23:16] data_byte,
  // [31:24] byte_index, [47:32] error_count
  output logic [47:0]                   m_tdata,
  output logic [spd_pkg::EVENT_W-1:0]   m_tuser,   // [2:0] event_res
  input  logic                          cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spd_pkg::CFG_W-1:0]     cfg_data
);
  import spd_pkg::*;

  logic              take;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  cfg_write_t        cfg;
  result_t           res;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  spd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_byte   (s_tdata),
    .take     (take),
    .in_valid (in_valid),
    .in_byte  (in_byte)
  );

  spd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_byte   (in_byte),
    .take      (take),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tuser = res.event_res;
  assign m_tdata = {res.error_count, res.byte_index, res.data_byte,
                    res.packet_length, res.msg_id};

endmodule

// ===== rtl/spd_checker.sv =====
module spd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [47:0]                 m_tdata,
  input logic [spd_pkg::EVENT_W-1:0] m_tuser
);
  import spd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser <= EV_SYNC)
    else $error("undefined event code");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == EV_DATA |-> m_tdata[31:24] < m_tdata[15:8])
    else $error("payload index beyond length");

  a_no_stray_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != EV_DATA |-> m_tdata[31:16] == 16'd0)
    else $error("data or index set outside a payload item");

endmodule

bind sync_packet_deframer spd_checker u_spd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
